>>> rtl/core/rpp_pkg.sv
// Shared types, codes and constants of the pixel post-process core.
// Holds the controller state encoding, the command and status bundles and
// the gamma curve entry function. No dependencies.
package rpp_pkg;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_DEPTH  = 2'd1,
    MODE_NORMAL = 2'd2,
    MODE_BLACK  = 2'd3
  } mode_t;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  localparam logic [15:0] PIX_ONE     = 16'hFFFF;
  localparam logic [31:0] SCALE_NUM   = 32'hFFFF_0000;
  localparam logic [31:0] SCALE_SAT   = 32'hFFFF_FFFF;
  localparam logic [5:0]  STEPS_COMP  = 6'd16;
  localparam logic [5:0]  STEPS_SCALE = 6'd32;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_DISPATCH = 9'b000000010,
    ST_SCRUN    = 9'b000000100,
    ST_DSTART   = 9'b000001000,
    ST_DRUN     = 9'b000010000,
    ST_LUT      = 9'b000100000,
    ST_MUL      = 9'b001000000,
    ST_STORE    = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_t;

  typedef struct packed {
    logic       capture;
    logic       clip_clr;
    logic       div_comp;
    logic       div_scale;
    logic       scale_sat;
    logic       scale_store;
    logic       lut_rd;
    logic       mul_en;
    logic       res_store;
    logic       out_load;
    logic [1:0] comp_idx;
  } cmd_t;

  typedef struct packed {
    logic  in_op;
    mode_t mode;
    logic  stale;
    logic  max_pos;
    logic  div_done;
  } sts_t;

  // Largest y with (y/65535)^11 <= (i/2^tb)^5, evaluated at elaboration.
  function automatic logic [15:0] gamma_entry(int unsigned i, int unsigned tb);
    logic [255:0] rhs;
    logic [255:0] lhs;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    rhs = 256'd1;
    for (int k = 0; k < 5; k++) rhs = rhs * 256'(i);
    for (int k = 0; k < 11; k++) rhs = rhs * 256'd65535;
    lo = 0;
    hi = 65535;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 256'd1;
      for (int k = 0; k < 11; k++) lhs = lhs * 256'(mid);
      lhs = lhs << (5 * tb);
      if (lhs <= rhs) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return 16'(lo);
  endfunction

endpackage

>>> rtl/core/rpp_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Used by rpp_datapath; depends on nothing else.
module rpp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] rem_init,
  input  logic [31:0] dvd_bits,
  input  logic [5:0]  steps,
  input  logic [31:0] divisor,
  output logic [31:0] quo,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvd_r, dvd_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] trial;
  logic        ge;

  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    ge       = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      rem_nxt  = rem_init;
      dvd_nxt  = dvd_bits;
      quo_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, dsr_r}) : trial[31:0];
      dvd_nxt = {dvd_r[30:0], 1'b0};
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

>>> rtl/core/rpp_ctrl.sv
// Controller state machine of the pixel post-process core.
// Sequences capture, divisions, table reads, products and result stores.
// Depends on rpp_pkg.
module rpp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rpp_pkg::sts_t sts,
  output rpp_pkg::cmd_t cmd
);

  rpp_pkg::state_t state_r, state_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            ovld_r, ovld_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.comp_idx = idx_r;
    in_tready    = 1'b0;
    unique case (state_r)
      rpp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          if (sts.in_op == rpp_pkg::OP_PROCESS) begin
            state_nxt = rpp_pkg::ST_DISPATCH;
          end
        end
      end
      rpp_pkg::ST_DISPATCH: begin
        cmd.clip_clr = 1'b1;
        idx_nxt      = 2'd0;
        unique case (sts.mode)
          rpp_pkg::MODE_FULL: state_nxt = rpp_pkg::ST_DSTART;
          rpp_pkg::MODE_DEPTH: begin
            if (sts.stale && sts.max_pos) begin
              cmd.div_scale = 1'b1;
              state_nxt     = rpp_pkg::ST_SCRUN;
            end else begin
              cmd.scale_sat = sts.stale;
              state_nxt     = rpp_pkg::ST_MUL;
            end
          end
          default: state_nxt = rpp_pkg::ST_STORE;
        endcase
      end
      rpp_pkg::ST_SCRUN: begin
        if (sts.div_done) begin
          cmd.scale_store = 1'b1;
          state_nxt       = rpp_pkg::ST_MUL;
        end
      end
      rpp_pkg::ST_DSTART: begin
        cmd.div_comp = 1'b1;
        state_nxt    = rpp_pkg::ST_DRUN;
      end
      rpp_pkg::ST_DRUN: begin
        if (sts.div_done) begin
          state_nxt = rpp_pkg::ST_LUT;
        end
      end
      rpp_pkg::ST_LUT: begin
        cmd.lut_rd = 1'b1;
        state_nxt  = rpp_pkg::ST_STORE;
      end
      rpp_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = rpp_pkg::ST_STORE;
      end
      rpp_pkg::ST_STORE: begin
        cmd.res_store = 1'b1;
        if (idx_r == 2'd2) begin
          state_nxt = rpp_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + 2'd1;
          unique case (sts.mode)
            rpp_pkg::MODE_FULL:  state_nxt = rpp_pkg::ST_DSTART;
            rpp_pkg::MODE_DEPTH: state_nxt = rpp_pkg::ST_MUL;
            default:             state_nxt = rpp_pkg::ST_STORE;
          endcase
        end
      end
      rpp_pkg::ST_DONE: begin
        if (!ovld_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = rpp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ovld_nxt = ovld_r;
    if (cmd.out_load) begin
      ovld_nxt = 1'b1;
    end else if (out_tready) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpp_pkg::ST_IDLE;
      idx_r   <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;

endmodule

>>> rtl/core/rpp_datapath.sv
// Datapath of the pixel post-process core: input and state registers,
// shared divider, gamma table, depth multiplier and output register.
// Depends on rpp_pkg and rpp_div.
module rpp_datapath #(
  parameter int FRAC_BITS        = 16,
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    in_tuser,
  input  logic [95:0]   in_tdata,
  output logic [0:0]    out_tuser,
  output logic [47:0]   out_tdata,
  input  logic          cfg_wr_en,
  input  logic [1:0]    cfg_wr_data,
  input  rpp_pkg::cmd_t cmd,
  output rpp_pkg::sts_t sts
);

  localparam int TAB = 1 << GAMMA_TABLE_BITS;
  localparam logic signed [32:0] ONE_F = 33'(1) << FRAC_BITS;

  logic [15:0] gamma_rom [TAB];
  for (genvar g = 0; g < TAB; g++) begin : g_rom
    assign gamma_rom[g] = rpp_pkg::gamma_entry(g, GAMMA_TABLE_BITS);
  end

  logic signed [31:0] comp_r [3];
  rpp_pkg::mode_t     mode_r;
  logic signed [31:0] max_r, max_nxt;
  logic [31:0]        scale_r;
  logic               stale_r;
  logic [62:0]        prod_r;
  logic [15:0]        lut_q_r;
  logic [15:0]        res_r [3];
  logic               clip_r;
  logic [47:0]        odata_r;
  logic               oclip_r;

  logic signed [31:0] x;
  logic signed [31:0] in_c0;
  logic               neg;
  logic               zero_vec;
  logic [46:0]        fn;
  logic [31:0]        div_rem, div_dvd, div_dsr, quo;
  logic [5:0]         div_steps;
  logic               div_done;
  logic [GAMMA_TABLE_BITS-1:0] lut_addr;
  logic signed [32:0] nrm_s;
  logic [47:0]        nrm_p, nrm_v;
  logic [15:0]        val;
  logic               vclip;

  always_comb begin
    unique case (cmd.comp_idx)
      2'd0:    x = comp_r[0];
      2'd1:    x = comp_r[1];
      default: x = comp_r[2];
    endcase
  end

  assign neg      = x[31];
  assign zero_vec = (comp_r[0] == 0) && (comp_r[1] == 0) && (comp_r[2] == 0);
  assign fn       = {x[30:0], 16'h0000} - 47'(x[30:0]);

  always_comb begin
    if (cmd.div_scale) begin
      div_rem   = '0;
      div_dvd   = rpp_pkg::SCALE_NUM;
      div_steps = rpp_pkg::STEPS_SCALE;
      div_dsr   = max_r;
    end else begin
      div_rem   = {16'h0000, fn[46:31]} << 15 | 32'(fn[30:16]);
      div_dvd   = {fn[15:0], 16'h0000};
      div_steps = rpp_pkg::STEPS_COMP;
      div_dsr   = 32'(x[30:0]) + 32'(ONE_F);
    end
  end

  rpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_comp | cmd.div_scale),
    .rem_init (div_rem),
    .dvd_bits (div_dvd),
    .steps    (div_steps),
    .divisor  (div_dsr),
    .quo      (quo),
    .done     (div_done)
  );

  assign lut_addr = neg ? '0 : quo[15 -: GAMMA_TABLE_BITS];

  assign nrm_s = {x[31], x} + ONE_F;
  assign nrm_p = {nrm_s[31:0], 16'h0000} - {16'h0000, nrm_s[31:0]};
  assign nrm_v = nrm_p >> (FRAC_BITS + 1);

  always_comb begin
    val   = '0;
    vclip = 1'b0;
    unique case (mode_r)
      rpp_pkg::MODE_FULL: begin
        val   = lut_q_r;
        vclip = neg;
      end
      rpp_pkg::MODE_DEPTH: begin
        if (zero_vec) begin
          val = rpp_pkg::PIX_ONE;
        end else if (neg) begin
          vclip = 1'b1;
        end else if (prod_r[62:32] != 0) begin
          val   = rpp_pkg::PIX_ONE;
          vclip = 1'b1;
        end else begin
          val = prod_r[31:16];
        end
      end
      rpp_pkg::MODE_NORMAL: begin
        if (zero_vec) begin
          val = '0;
        end else if (nrm_s[32]) begin
          vclip = 1'b1;
        end else if (nrm_v > 48'd65535) begin
          val   = rpp_pkg::PIX_ONE;
          vclip = 1'b1;
        end else begin
          val = nrm_v[15:0];
        end
      end
      default: begin
        val   = '0;
        vclip = 1'b0;
      end
    endcase
  end

  assign in_c0 = in_tdata[31:0];

  always_comb begin
    max_nxt = in_tuser[1] ? 32'sd0 : max_r;
    if (in_c0 > max_nxt) begin
      max_nxt = in_c0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rpp_pkg::MODE_FULL;
      max_r   <= '0;
      scale_r <= '0;
      stale_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= rpp_pkg::mode_t'(cfg_wr_data);
      end
      if (cmd.capture && in_tuser[0] == rpp_pkg::OP_MEASURE) begin
        max_r   <= max_nxt;
        stale_r <= 1'b1;
      end
      if (cmd.scale_sat) begin
        scale_r <= rpp_pkg::SCALE_SAT;
        stale_r <= 1'b0;
      end
      if (cmd.scale_store) begin
        scale_r <= quo;
        stale_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      comp_r[0] <= in_tdata[31:0];
      comp_r[1] <= in_tdata[63:32];
      comp_r[2] <= in_tdata[95:64];
    end
    if (cmd.lut_rd) begin
      lut_q_r <= gamma_rom[lut_addr];
    end
    if (cmd.mul_en) begin
      prod_r <= 63'(x[30:0]) * 63'(scale_r);
    end
    if (cmd.clip_clr) begin
      clip_r <= 1'b0;
    end else if (cmd.res_store) begin
      clip_r <= clip_r | vclip;
    end
    if (cmd.res_store) begin
      unique case (cmd.comp_idx)
        2'd0:    res_r[0] <= val;
        2'd1:    res_r[1] <= val;
        default: res_r[2] <= val;
      endcase
    end
    if (cmd.out_load) begin
      odata_r <= {res_r[2], res_r[1], res_r[0]};
      oclip_r <= clip_r;
    end
  end

  assign sts.in_op    = in_tuser[0];
  assign sts.mode     = mode_r;
  assign sts.stale    = stale_r;
  assign sts.max_pos  = max_r > 32'sd0;
  assign sts.div_done = div_done;

  assign out_tdata = odata_r;
  assign out_tuser = oclip_r;

endmodule

>>> rtl/core/render_pixel_post_process_core.sv
// Pixel post-process core: tone map with gamma, depth scale, normal remap.
// The in_ channel carries Q16.16 pixels of a measure pass and a process pass;
// the out_ channel gives one Q0.16 pixel per process beat.
// Measure beats (tuser bit 0 low) update the running depth maximum in the
// capture cycle and give no output beat. Process beats give one output beat.
// A process beat in full mode runs three 16-step divisions on the shared
// restoring divider plus a table read each. Depth mode multiplies each
// component by the scale, recomputed by a 32-step division after a measure
// pass. One beat is worked on at a time; in_tready is high only while idle.
// The output register holds a finished beat while the receiver stalls, and
// the next input beat is taken meanwhile; its result waits until the slot
// is free. Reset clears the mode to full, the maximum and scale to zero, and
// marks the scale stale. cfg_wr_en writes the two-bit mode; the user must
// write it only while idle, which the block itself does not enforce.
// Depends on rpp_pkg, rpp_ctrl and rpp_datapath.
module render_pixel_post_process_core #(
  parameter int FRAC_BITS        = 16,
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // comp_a, comp_b, comp_c
  input  logic [1:0]  in_tuser,   // operation, frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_a, out_b, out_c
  output logic [0:0]  out_tuser,  // clipped
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data
);

  rpp_pkg::cmd_t cmd;
  rpp_pkg::sts_t sts;

  rpp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpp_datapath #(
    .FRAC_BITS        (FRAC_BITS),
    .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
